// ----- hw/rtl/sslc_pkg.sv -----
package sslc_pkg;

    // number of names: the response prefix then the fourteen methods
    localparam int NAME_COUNT  = 15;
    localparam int NAME_CHARS  = 9;
    localparam int PREFIX_LEN  = 7;
    localparam int POS_W       = 4;
    localparam int ID_W        = 4;
    localparam int MAG_W       = 15;
    localparam int STATUS_W    = 16;
    localparam logic [MAG_W-1:0] STATUS_MAX = 15'd32767;

    typedef enum logic [2:0] {
        PH_PREFIX = 3'd0,
        PH_SKIP   = 3'd1,
        PH_LEAD   = 3'd2,
        PH_DIGITS = 3'd3,
        PH_DONE   = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        KIND_REQUEST  = 2'd0,
        KIND_RESPONSE = 2'd1,
        KIND_UNKNOWN  = 2'd2
    } t_kind;

    // status parser state
    typedef struct packed {
        t_phase           phase;
        logic             neg;
        logic [MAG_W-1:0] mag;
    } t_num_state;

    // names left-justified, padded with spaces to nine characters
    localparam logic [8*NAME_CHARS-1:0] NAME_TAB [NAME_COUNT] = '{
        "SIP/2.0  ", "INVITE   ", "UPDATE   ", "BYE      ", "ACK      ",
        "CANCEL   ", "OPTIONS  ", "REGISTER ", "INFO     ", "PRACK    ",
        "MESSAGE  ", "SUBSCRIBE", "NOTIFY   ", "REFER    ", "PUBLISH  "
    };

    localparam logic [POS_W-1:0] NAME_LEN [NAME_COUNT] = '{
        4'd7, 4'd6, 4'd6, 4'd3, 4'd3, 4'd6, 4'd7, 4'd8,
        4'd4, 4'd5, 4'd7, 4'd9, 4'd6, 4'd5, 4'd7
    };

endpackage

// ----- hw/rtl/sslc_match.sv -----
module sslc_match (
    input  logic [7:0]                          i_byte,
    input  logic [sslc_pkg::POS_W-1:0]          i_pos,
    input  logic [sslc_pkg::POS_W-1:0]          i_after,
    input  logic                                i_active,
    input  logic [sslc_pkg::NAME_COUNT-1:0]     i_mask,
    output logic [sslc_pkg::NAME_COUNT-1:0]     o_mask,
    output logic                                o_prefix_hit,
    output logic                                o_resp,
    output logic [sslc_pkg::ID_W-1:0]           o_method_id
);

    logic [7:0] folded;

    // only ascii lower-case letters are folded
    always_comb begin
        if (i_byte inside {[8'h61:8'h7A]}) begin
            folded = i_byte - 8'h20;
        end else begin
            folded = i_byte;
        end
    end

    // drop every name whose character at this position differs
    always_comb begin
        o_mask = i_mask;
        if (i_active) begin
            for (int i = 0; i < sslc_pkg::NAME_COUNT; i++) begin
                if (i_pos < sslc_pkg::NAME_LEN[i] &&
                    sslc_pkg::NAME_TAB[i][8*sslc_pkg::NAME_CHARS-1-8*i_pos -: 8] != folded) begin
                    o_mask[i] = 1'b0;
                end
            end
        end
    end

    assign o_prefix_hit = i_active && (i_pos == 4'(sslc_pkg::PREFIX_LEN - 1)) && o_mask[0];
    assign o_resp       = o_mask[0] && (i_after >= 4'(sslc_pkg::PREFIX_LEN));

    // first surviving, fully seen method in table order
    always_comb begin
        o_method_id = '0;
        for (int i = sslc_pkg::NAME_COUNT - 1; i >= 1; i--) begin
            if (o_mask[i] && i_after >= sslc_pkg::NAME_LEN[i]) begin
                o_method_id = sslc_pkg::ID_W'(i);
            end
        end
    end

endmodule

// ----- hw/rtl/sslc_status.sv -----
module sslc_status (
    input  logic [7:0]           i_byte,
    input  logic                 i_prefix_hit,
    input  sslc_pkg::t_num_state i_state,
    output sslc_pkg::t_num_state o_state
);

    logic        is_digit;
    logic [3:0]  digit;
    logic [18:0] prod;
    logic [sslc_pkg::MAG_W-1:0] acc;

    assign is_digit = i_byte inside {[8'h30:8'h39]};
    assign digit    = i_byte[3:0];

    // magnitude times ten plus digit, saturated
    always_comb begin
        prod = ({4'd0, i_state.mag} << 3) + ({4'd0, i_state.mag} << 1) + {15'd0, digit};
        if (prod > {4'd0, sslc_pkg::STATUS_MAX}) begin
            acc = sslc_pkg::STATUS_MAX;
        end else begin
            acc = prod[sslc_pkg::MAG_W-1:0];
        end
    end

    always_comb begin
        o_state = i_state;
        case (i_state.phase)
            sslc_pkg::PH_PREFIX: begin
                if (i_prefix_hit) begin
                    o_state.phase = sslc_pkg::PH_SKIP;
                end
            end
            sslc_pkg::PH_SKIP: begin
                o_state.phase = sslc_pkg::PH_LEAD;
            end
            sslc_pkg::PH_LEAD: begin
                if (i_byte inside {8'h20, [8'h09:8'h0D]}) begin
                    o_state.phase = sslc_pkg::PH_LEAD;
                end else if (i_byte inside {8'h2B, 8'h2D}) begin
                    o_state.neg   = (i_byte == 8'h2D);
                    o_state.phase = sslc_pkg::PH_DIGITS;
                end else if (is_digit) begin
                    o_state.mag   = acc;
                    o_state.phase = sslc_pkg::PH_DIGITS;
                end else begin
                    o_state.phase = sslc_pkg::PH_DONE;
                end
            end
            sslc_pkg::PH_DIGITS: begin
                if (is_digit) begin
                    o_state.mag = acc;
                end else begin
                    o_state.phase = sslc_pkg::PH_DONE;
                end
            end
            default: begin
                o_state = i_state;
            end
        endcase
    end

endmodule

// ----- hw/rtl/sip_start_line_classifier.sv -----
// channel  | dir | tdata (low bit up)                      | tuser      | tlast
// s        | in  | data_byte[7:0]                          | -          | last_byte
// m        | out | method_id[3:0], status_code[19:4], pad  | line_kind  | -
//
// one item per cycle sustained unless a last item is held back by a full result
// register; an input item lands in the input register, and when it advances, name
// matching and status parsing run on it and a last item loads the result register
// reset (synchronous, i_rst_n low) clears both valid flags and the line state
// a full result register stalls the input only when a last item waits to leave
module sip_start_line_classifier (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // data_byte[7:0]
    input  logic        i_s_tlast,   // last_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // method_id[3:0], status_code[19:4], zero pad
    output logic [1:0]  o_m_tuser    // line_kind[1:0]
);

    // input register
    logic       r_in_vld;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // line state
    logic [sslc_pkg::POS_W-1:0]      r_pos;
    logic [sslc_pkg::NAME_COUNT-1:0] r_mask;
    sslc_pkg::t_num_state            r_num;

    // result register
    logic                            r_out_vld;
    sslc_pkg::t_kind                 r_out_kind;
    logic [sslc_pkg::ID_W-1:0]       r_out_id;
    logic [sslc_pkg::STATUS_W-1:0]   r_out_status;

    logic                            n_out_vld;
    sslc_pkg::t_kind                 n_out_kind;
    logic [sslc_pkg::ID_W-1:0]       n_out_id;
    logic [sslc_pkg::STATUS_W-1:0]   n_out_status;

    logic [sslc_pkg::POS_W-1:0]      n_pos;
    logic [sslc_pkg::NAME_COUNT-1:0] n_mask;
    sslc_pkg::t_num_state            n_num;

    logic                            s_accept;
    logic                            advance;
    logic                            prefix_hit;
    logic                            is_resp;
    logic [sslc_pkg::ID_W-1:0]       method_id;
    logic [sslc_pkg::STATUS_W-1:0]   mag_ext;

    // a non-last item never needs the result slot
    assign advance    = r_in_vld && (!r_in_last || !r_out_vld || i_m_tready);
    assign o_s_tready = !r_in_vld || advance;
    assign s_accept   = i_s_tvalid && o_s_tready;

    // position saturates at fifteen
    assign n_pos = (r_pos == '1) ? r_pos : r_pos + 1'b1;

    sslc_match u_match (
        .i_byte       (r_in_byte),
        .i_pos        (r_pos),
        .i_after      (n_pos),
        .i_active     (r_num.phase == sslc_pkg::PH_PREFIX),
        .i_mask       (r_mask),
        .o_mask       (n_mask),
        .o_prefix_hit (prefix_hit),
        .o_resp       (is_resp),
        .o_method_id  (method_id)
    );

    sslc_status u_status (
        .i_byte       (r_in_byte),
        .i_prefix_hit (prefix_hit),
        .i_state      (r_num),
        .o_state      (n_num)
    );

    assign mag_ext = {1'b0, n_num.mag};

    // classification of the line that ends with this item
    always_comb begin
        n_out_kind   = sslc_pkg::KIND_UNKNOWN;
        n_out_id     = '0;
        n_out_status = '0;
        if (is_resp) begin
            n_out_kind   = sslc_pkg::KIND_RESPONSE;
            n_out_status = n_num.neg ? (~mag_ext + 1'b1) : mag_ext;
        end else if (method_id != '0) begin
            n_out_kind = sslc_pkg::KIND_REQUEST;
            n_out_id   = method_id;
        end
    end

    always_comb begin
        if (advance && r_in_last) begin
            n_out_vld = 1'b1;
        end else if (i_m_tready) begin
            n_out_vld = 1'b0;
        end else begin
            n_out_vld = r_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_accept) begin
            r_in_vld <= 1'b1;
        end else if (advance) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_in_byte <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
    end

    // line state returns to its start values after the last item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_mask  <= '1;
            r_num   <= '{phase: sslc_pkg::PH_PREFIX, neg: 1'b0, mag: '0};
        end else if (advance) begin
            if (r_in_last) begin
                r_pos  <= '0;
                r_mask <= '1;
                r_num  <= '{phase: sslc_pkg::PH_PREFIX, neg: 1'b0, mag: '0};
            end else begin
                r_pos  <= n_pos;
                r_mask <= n_mask;
                r_num  <= n_num;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_last) begin
            r_out_kind   <= n_out_kind;
            r_out_id     <= n_out_id;
            r_out_status <= n_out_status;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {4'd0, r_out_status, r_out_id};
    assign o_m_tuser  = r_out_kind;

endmodule
